// ----- rtl/bmhq_pkg.sv -----
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared widths, codes and the entry type of the binary min-heap queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

	localparam int Capacity  = 256;
	localparam int AddrBits  = $clog2(Capacity);
	localparam int CountBits = $clog2(Capacity + 1);
	localparam int KeyBits   = 16;
	localparam int TagBits   = 16;

	localparam logic [2:0] OP_PUSH     = 3'd0;
	localparam logic [2:0] OP_POP      = 3'd1;
	localparam logic [2:0] OP_REPL_ONE = 3'd2;
	localparam logic [2:0] OP_REPL_ALL = 3'd3;
	localparam logic [2:0] OP_CONTAINS = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_MISS  = 2'd3;

	typedef logic [AddrBits-1:0]  addr_t;
	typedef logic [CountBits-1:0] cnt_t;

	typedef struct packed {
		logic [KeyBits-1:0] key;
		logic [TagBits-1:0] tag;
	} entry_t;

endpackage

// ----- rtl/binary_min_heap_queue.sv -----
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Priority queue kept as a binary min-heap in one synchronous memory.
// ----------------------------------------------------------------------------
// Push sifts the new entry up and pop sifts the last entry down from the root;
// scans visit the slots in order and sift each replaced entry.
// A refused push or pop or an unknown operation answers in the cycle after start.
// One request at a time; busy is high meanwhile. The heap memory is read one slot
// at a time. The receiver cannot stall the done cycle.
// Reset empties the queue; memory contents are not cleared.
module binary_min_heap_queue (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [2:0]                      op,
	input  logic [bmhq_pkg::KeyBits-1:0]    key,
	input  logic [bmhq_pkg::TagBits-1:0]    tag,
	input  logic [bmhq_pkg::KeyBits-1:0]    new_key,
	input  logic [bmhq_pkg::TagBits-1:0]    new_tag,
	output logic                            done,
	output logic [1:0]                      status,
	output logic [bmhq_pkg::KeyBits-1:0]    out_key,
	output logic [bmhq_pkg::TagBits-1:0]    out_tag,
	output logic                            found,
	output logic [bmhq_pkg::CountBits-1:0]  count
);
	import bmhq_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_POP2   = 4'd1;
	localparam logic [3:0] S_POP3   = 4'd2;
	localparam logic [3:0] S_UP_RD  = 4'd3;
	localparam logic [3:0] S_UP_CMP = 4'd4;
	localparam logic [3:0] S_DN_RDL = 4'd5;
	localparam logic [3:0] S_DN_RDR = 4'd6;
	localparam logic [3:0] S_DN_CMP = 4'd7;
	localparam logic [3:0] S_FIN    = 4'd8;
	localparam logic [3:0] S_SC_RD  = 4'd9;
	localparam logic [3:0] S_SC_CHK = 4'd10;

	entry_t mem [Capacity];
	entry_t rdata;
	logic   re, we;
	addr_t  raddr, waddr;
	entry_t wdata;

	logic [3:0]         state_q;
	logic [2:0]         op_q;
	logic [TagBits-1:0] tag_q;
	entry_t             new_q, cur_q, lft_q;
	addr_t              pos_q, par_q;
	cnt_t               cnt_q, idx_q;
	logic               has_r_q;
	logic               done_q, found_q;
	logic [1:0]         status_q;
	entry_t             out_q;

	logic [CountBits:0] left_w, right_w;
	addr_t              best_w;
	entry_t             beste_w;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

	assign left_w  = {1'b0, pos_q, 1'b1};
	assign right_w = {1'b0, pos_q, 1'b0} + 2'd2;

	always_comb begin
		best_w  = pos_q;
		beste_w = cur_q;
		if (lft_q.key < beste_w.key) begin
			best_w  = left_w[AddrBits-1:0];
			beste_w = lft_q;
		end
		if (has_r_q && rdata.key < beste_w.key) begin
			best_w  = right_w[AddrBits-1:0];
			beste_w = rdata;
		end
	end

	always_comb begin
		re    = 1'b0;
		raddr = '0;
		we    = 1'b0;
		waddr = pos_q;
		wdata = cur_q;
		case (state_q)
			S_IDLE: begin
				re    = start && op == OP_POP;
				raddr = '0;
			end
			S_POP2: begin
				re    = 1'b1;
				raddr = addr_t'(cnt_q - 1'b1);
			end
			S_UP_RD: begin
				if (pos_q == '0) begin
					we = 1'b1;
				end else begin
					re    = 1'b1;
					raddr = (pos_q - 1'b1) >> 1;
				end
			end
			S_UP_CMP: begin
				we = 1'b1;
				if (cur_q.key < rdata.key) begin
					wdata = rdata;
				end
			end
			S_DN_RDL: begin
				if (left_w >= {1'b0, cnt_q}) begin
					we = 1'b1;
				end else begin
					re    = 1'b1;
					raddr = left_w[AddrBits-1:0];
				end
			end
			S_DN_RDR: begin
				re    = right_w < {1'b0, cnt_q};
				raddr = right_w[AddrBits-1:0];
			end
			S_DN_CMP: begin
				we    = 1'b1;
				wdata = beste_w;
			end
			S_SC_RD: begin
				re    = idx_q < cnt_q;
				raddr = idx_q[AddrBits-1:0];
			end
			S_SC_CHK: begin
				if (rdata.tag == tag_q && op_q != OP_CONTAINS
						&& new_q.key == rdata.key) begin
					we    = 1'b1;
					waddr = idx_q[AddrBits-1:0];
					wdata = new_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			done_q   <= 1'b0;
			status_q <= ST_OK;
			found_q  <= 1'b0;
			out_q    <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q     <= op;
						tag_q    <= tag;
						new_q    <= '{key: new_key, tag: new_tag};
						found_q  <= 1'b0;
						status_q <= ST_OK;
						out_q    <= '0;
						idx_q    <= '0;
						case (op)
							OP_PUSH: begin
								if (cnt_q == cnt_t'(Capacity)) begin
									status_q <= ST_FULL;
									done_q   <= 1'b1;
								end else begin
									cur_q   <= '{key: key, tag: tag};
									pos_q   <= cnt_q[AddrBits-1:0];
									cnt_q   <= cnt_q + 1'b1;
									state_q <= S_UP_RD;
								end
							end
							OP_POP: begin
								if (cnt_q == '0) begin
									status_q <= ST_EMPTY;
									done_q   <= 1'b1;
								end else begin
									state_q <= S_POP2;
								end
							end
							OP_REPL_ONE, OP_REPL_ALL, OP_CONTAINS: begin
								state_q <= S_SC_RD;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_POP2: begin
					out_q   <= rdata;
					cnt_q   <= cnt_q - 1'b1;
					state_q <= S_POP3;
				end
				S_POP3: begin
					cur_q   <= rdata;
					pos_q   <= '0;
					state_q <= S_DN_RDL;
				end
				S_UP_RD: begin
					if (pos_q == '0) begin
						state_q <= S_FIN;
					end else begin
						par_q   <= (pos_q - 1'b1) >> 1;
						state_q <= S_UP_CMP;
					end
				end
				S_UP_CMP: begin
					if (cur_q.key < rdata.key) begin
						pos_q   <= par_q;
						state_q <= S_UP_RD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_DN_RDL: begin
					if (left_w >= {1'b0, cnt_q}) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_DN_RDR;
					end
				end
				S_DN_RDR: begin
					lft_q   <= rdata;
					has_r_q <= right_w < {1'b0, cnt_q};
					state_q <= S_DN_CMP;
				end
				S_DN_CMP: begin
					if (best_w == pos_q) begin
						state_q <= S_FIN;
					end else begin
						pos_q   <= best_w;
						state_q <= S_DN_RDL;
					end
				end
				S_FIN: begin
					if (op_q == OP_REPL_ALL) begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_SC_RD;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_SC_RD: begin
					if (idx_q < cnt_q) begin
						state_q <= S_SC_CHK;
					end else begin
						status_q <= found_q ? ST_OK : ST_MISS;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				S_SC_CHK: begin
					if (rdata.tag == tag_q) begin
						found_q <= 1'b1;
						if (op_q == OP_CONTAINS) begin
							out_q   <= rdata;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							cur_q <= new_q;
							pos_q <= idx_q[AddrBits-1:0];
							if (new_q.key < rdata.key) begin
								state_q <= S_UP_RD;
							end else if (new_q.key > rdata.key) begin
								state_q <= S_DN_RDL;
							end else begin
								state_q <= S_FIN;
							end
						end
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_SC_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy    = state_q != S_IDLE;
	assign done    = done_q;
	assign status  = status_q;
	assign out_key = out_q.key;
	assign out_tag = out_q.tag;
	assign found   = found_q;
	assign count   = cnt_q;

endmodule
